FILE: rtl/core/sqvg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvg_pkg: shared types, widths and trig table for the sprite quad generator
// Field widths, intermediate widths, corner order and the quarter-wave sine
// table built at elaboration from a fixed-point Taylor series.
// ----------------------------------------------------------------------------
package sqvg_pkg;

  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int TRIG_FRACTION_BITS = 15;

  localparam int IDX_W   = $clog2(SINE_TABLE_ENTRIES);
  localparam int QUARTER = SINE_TABLE_ENTRIES / 4;
  localparam int QJ_W    = IDX_W - 2;
  localparam int TRIG_W  = TRIG_FRACTION_BITS + 1;
  localparam int TRIG_SW = TRIG_FRACTION_BITS + 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int DIM_W   = 12;
  localparam int SCALE_W = 16;
  localparam int CROP_W  = 17;
  localparam int POS_W   = 24;
  localparam int UV_W    = 16;
  localparam int COLOR_W = 32;
  localparam int ANGLE_W = 16;
  localparam int VNUM_W  = 3;

  localparam int SW_W   = DIM_W + SCALE_W;
  localparam int SH_W   = SW_W;
  localparam int XOP_W  = SW_W + CROP_W;
  localparam int XO_W   = XOP_W - 15;
  localparam int DC_W   = CROP_W + 1;
  localparam int CWP_W  = SW_W + 1 + DC_W;
  localparam int CW_W   = CWP_W - 16;
  localparam int CX2_W  = CW_W + 3;
  localparam int CY2_W  = SH_W + 2;
  localparam int UWP_W  = UV_W + 1 + DC_W;
  localparam int ULR_W  = UWP_W - 16;
  localparam int ULS_W  = ULR_W + 1;
  localparam int PROD_W = CW_W + TRIG_SW;
  localparam int ACC_W  = CX2_W + TRIG_FRACTION_BITS + 2;
  localparam int RND_W  = ACC_W - TRIG_FRACTION_BITS - 1;

  localparam int ROUND16    = 1 << 15;
  localparam int ROUND_TRIG = 1 << TRIG_FRACTION_BITS;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // Corner order BL, TL, BR, BR, TL, TR; bit k belongs to vertex k
  localparam int NUM_CORNERS = 6;
  localparam logic [NUM_CORNERS-1:0] CORNER_RIGHT = 6'b101100;
  localparam logic [NUM_CORNERS-1:0] CORNER_TOP   = 6'b110010;
  localparam logic [VNUM_W-1:0] FIRST_CORNER = 3'd0;
  localparam logic [VNUM_W-1:0] LAST_CORNER  = 3'd5;

  typedef logic [QUARTER-1:0][TRIG_W-1:0] qtab_t;

  typedef struct packed {
    logic signed [CX2_W-1:0]   cx2;
    logic signed [CY2_W-1:0]   cy2;
    logic signed [CW_W-1:0]    cw;
    logic [SH_W-1:0]           sh;
    logic signed [TRIG_SW-1:0] sn;
    logic signed [TRIG_SW-1:0] cn;
    logic [UV_W-1:0]           ul;
    logic [UV_W-1:0]           ur;
    logic [UV_W-1:0]           vmin;
    logic [UV_W-1:0]           vmax;
    logic [COLOR_W-1:0]        color;
  } setup_t;

  // Sine of a quarter-wave step, Q30 series to x^13 with truncating steps
  function automatic logic [TRIG_W-1:0] quarter_entry(input int jj);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (64'(jj) * 64'd4 * HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
    x2   = (x * x) >> 30;
    term = ((x * x2) >> 30) / 64'd6;
    sum  = longint'(x) - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    x = 64'(sum) + (64'd1 << (29 - TRIG_FRACTION_BITS));
    return TRIG_W'(x >> (30 - TRIG_FRACTION_BITS));
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i < QUARTER; i++) begin
      t[i] = quarter_entry(i);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();
  localparam logic [TRIG_W-1:0] QPEAK = quarter_entry(QUARTER);

  // Signed table value for a quadrant and a step within it
  function automatic logic signed [TRIG_SW-1:0] trig_value(input logic [1:0] quad,
                                                          input logic [QJ_W-1:0] j);
    logic [QJ_W:0]              jj;
    logic [TRIG_W-1:0]          mag;
    logic signed [TRIG_SW-1:0]  sv;
    jj  = quad[0] ? (QJ_W+1)'(QUARTER) - {1'b0, j} : {1'b0, j};
    mag = jj[QJ_W] ? QPEAK : QTAB[jj[QJ_W-1:0]];
    sv  = $signed({1'b0, mag});
    return quad[1] ? -sv : sv;
  endfunction

endpackage

FILE: rtl/core/sqvg_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvg_setup: per-sprite setup pipeline
// Three register stages: size, crop delta, trig and UV products; crop
// products, doubled y centre, UV saturation; rounding, doubled x centre.
// ----------------------------------------------------------------------------
module sqvg_setup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sprite_valid,
  output logic                          sprite_stall,
  input  logic [sqvg_pkg::DIM_W-1:0]    sprite_width,
  input  logic [sqvg_pkg::DIM_W-1:0]    sprite_height,
  input  logic [2*sqvg_pkg::UV_W-1:0]   uv_min,
  input  logic [2*sqvg_pkg::UV_W-1:0]   uv_max,
  input  logic signed [sqvg_pkg::POS_W-1:0] base_x,
  input  logic signed [sqvg_pkg::POS_W-1:0] base_y,
  input  logic [sqvg_pkg::COLOR_W-1:0]  color_rgba,
  input  logic [sqvg_pkg::SCALE_W-1:0]  scale_factor,
  input  logic [sqvg_pkg::ANGLE_W-1:0]  rotation_angle,
  input  logic [sqvg_pkg::CROP_W-1:0]   crop_start,
  input  logic [sqvg_pkg::CROP_W-1:0]   crop_end,
  output logic                          result_valid,
  input  logic                          result_stall,
  output sqvg_pkg::setup_t              result
);
  import sqvg_pkg::*;

  function automatic logic [UV_W-1:0] sat_uv(input logic signed [ULR_W-1:0] r,
                                             input logic [UV_W-1:0] base);
    logic signed [ULS_W-1:0] s;
    s = ULS_W'(r) + ULS_W'($signed({1'b0, base}));
    if (s < 0) begin
      return '0;
    end else if (s > ULS_W'($signed({1'b0, {UV_W{1'b1}}}))) begin
      return {UV_W{1'b1}};
    end
    return s[UV_W-1:0];
  endfunction

  logic v1, v2;
  logic ready1, ready2, ready3;

  logic [IDX_W-1:0]          angle_idx;
  logic [1:0]                quad;
  logic [QJ_W-1:0]           qstep;
  logic signed [UV_W:0]      uw;
  logic signed [DC_W-1:0]    dc;

  logic [SW_W-1:0]           s1_sw;
  logic [SH_W-1:0]           s1_sh;
  logic [CROP_W-1:0]         s1_cs;
  logic signed [DC_W-1:0]    s1_dc;
  logic signed [POS_W-1:0]   s1_bx, s1_by;
  logic signed [TRIG_SW-1:0] s1_sn, s1_cn;
  logic [UV_W-1:0]           s1_umin, s1_vmin, s1_vmax;
  logic signed [UWP_W-1:0]   s1_ulp, s1_urp;
  logic [COLOR_W-1:0]        s1_color;

  logic [XOP_W-1:0]          s2_xop;
  logic signed [CWP_W-1:0]   s2_cwp;
  logic signed [POS_W-1:0]   s2_bx;
  logic signed [CY2_W-1:0]   s2_cy2;
  logic [SH_W-1:0]           s2_sh;
  logic signed [TRIG_SW-1:0] s2_sn, s2_cn;
  logic [UV_W-1:0]           s2_ul, s2_ur, s2_vmin, s2_vmax;
  logic [COLOR_W-1:0]        s2_color;

  logic [XO_W-1:0]           xo;
  logic signed [CW_W-1:0]    cw;

  assign ready3 = !result_valid || !result_stall;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign sprite_stall = !ready1;

  assign angle_idx = rotation_angle[ANGLE_W-1 -: IDX_W];
  assign quad      = angle_idx[IDX_W-1 -: 2];
  assign qstep     = angle_idx[QJ_W-1:0];
  assign uw = $signed({1'b0, uv_max[UV_W-1:0]}) - $signed({1'b0, uv_min[UV_W-1:0]});
  assign dc = $signed({1'b0, crop_end}) - $signed({1'b0, crop_start});

  assign xo = XO_W'(((XOP_W+1)'(s2_xop) + (XOP_W+1)'(ROUND16)) >> 16);
  assign cw = CW_W'((s2_cwp + CWP_W'(ROUND16)) >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= sprite_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        result_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_sw    <= SW_W'(sprite_width) * SW_W'(scale_factor);
      s1_sh    <= SH_W'(sprite_height) * SH_W'(scale_factor);
      s1_cs    <= crop_start;
      s1_dc    <= dc;
      s1_bx    <= base_x;
      s1_by    <= base_y;
      s1_sn    <= trig_value(quad, qstep);
      s1_cn    <= trig_value(quad + 2'd1, qstep);
      s1_umin  <= uv_min[UV_W-1:0];
      s1_vmin  <= uv_min[2*UV_W-1:UV_W];
      s1_vmax  <= uv_max[2*UV_W-1:UV_W];
      s1_ulp   <= UWP_W'(uw) * UWP_W'($signed({1'b0, crop_start}));
      s1_urp   <= UWP_W'(uw) * UWP_W'($signed({1'b0, crop_end}));
      s1_color <= color_rgba;
    end
    if (ready2) begin
      s2_xop   <= XOP_W'(s1_sw) * XOP_W'(s1_cs);
      s2_cwp   <= CWP_W'($signed({1'b0, s1_sw})) * CWP_W'(s1_dc);
      s2_bx    <= s1_bx;
      s2_cy2   <= CY2_W'($signed({s1_by, 1'b0})) + CY2_W'($signed({1'b0, s1_sh}));
      s2_sh    <= s1_sh;
      s2_sn    <= s1_sn;
      s2_cn    <= s1_cn;
      s2_ul    <= sat_uv(ULR_W'((s1_ulp + UWP_W'(ROUND16)) >>> 16), s1_umin);
      s2_ur    <= sat_uv(ULR_W'((s1_urp + UWP_W'(ROUND16)) >>> 16), s1_umin);
      s2_vmin  <= s1_vmin;
      s2_vmax  <= s1_vmax;
      s2_color <= s1_color;
    end
    if (ready3) begin
      result.cx2   <= CX2_W'($signed({s2_bx, 1'b0})) + CX2_W'($signed({1'b0, xo, 1'b0}))
                      + CX2_W'(cw);
      result.cy2   <= s2_cy2;
      result.cw    <= cw;
      result.sh    <= s2_sh;
      result.sn    <= s2_sn;
      result.cn    <= s2_cn;
      result.ul    <= s2_ul;
      result.ur    <= s2_ur;
      result.vmin  <= s2_vmin;
      result.vmax  <= s2_vmax;
      result.color <= s2_color;
    end
  end

endmodule

FILE: rtl/core/sprite_quad_vertex_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_vertex_generator: scaled, cropped, rotated sprite quad setup
// Takes one sprite per transfer and sends six vertices (BL, TL, BR, BR, TL,
// TR) with saturated Q16.8 position, Q1.15 UV and the sprite color.
//
//   channel  | signals                     | direction | payload
//   sprite   | sprite_valid / sprite_stall | in        | sprite fields
//   vertex   | vertex_valid / vertex_stall | out       | one corner per transfer
//
// The first vertex passes through three setup stages, a rotation product
// stage, a corner sum stage and the output register. Sprite throughput is
// set by the corner counter, which issues one vertex per cycle unless a
// vertex stall holds it; the next sprite waits in the setup stages.
// Reset clears valid bits and the corner counter only.
// A vertex stall holds every stage whose successor is full; nothing drops.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sprite_valid,
  output logic                              sprite_stall,
  input  logic [sqvg_pkg::DIM_W-1:0]        sprite_width,
  input  logic [sqvg_pkg::DIM_W-1:0]        sprite_height,
  input  logic [2*sqvg_pkg::UV_W-1:0]       uv_min,
  input  logic [2*sqvg_pkg::UV_W-1:0]       uv_max,
  input  logic signed [sqvg_pkg::POS_W-1:0] base_x,
  input  logic signed [sqvg_pkg::POS_W-1:0] base_y,
  input  logic [sqvg_pkg::COLOR_W-1:0]      color_rgba,
  input  logic [sqvg_pkg::SCALE_W-1:0]      scale_factor,
  input  logic [sqvg_pkg::ANGLE_W-1:0]      rotation_angle,
  input  logic [sqvg_pkg::CROP_W-1:0]       crop_start,
  input  logic [sqvg_pkg::CROP_W-1:0]       crop_end,
  output logic                              vertex_valid,
  input  logic                              vertex_stall,
  output logic [sqvg_pkg::VNUM_W-1:0]       vertex_number,
  output logic signed [sqvg_pkg::POS_W-1:0] vertex_x,
  output logic signed [sqvg_pkg::POS_W-1:0] vertex_y,
  output logic [sqvg_pkg::UV_W-1:0]         tex_u,
  output logic [sqvg_pkg::UV_W-1:0]         tex_v,
  output logic [sqvg_pkg::COLOR_W-1:0]      vertex_color,
  output logic                              last_vertex
);
  import sqvg_pkg::*;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [RND_W-1:0] r);
    if (r > RND_W'(POS_MAX)) begin
      return POS_MAX;
    end else if (r < RND_W'(POS_MIN)) begin
      return POS_MIN;
    end
    return r[POS_W-1:0];
  endfunction

  logic   s_valid;
  logic   s_stall;
  setup_t s_res;

  logic                     ev;
  logic [VNUM_W-1:0]        cnt;
  logic                     issue, e_done, e_ready;
  logic signed [CX2_W-1:0]  e_cx2;
  logic signed [CY2_W-1:0]  e_cy2;
  logic signed [PROD_W-1:0] e_pa, e_pb, e_pc, e_pd;
  logic [UV_W-1:0]          e_ul, e_ur, e_vmin, e_vmax;
  logic [COLOR_W-1:0]       e_color;

  logic                     right, top;
  logic signed [ACC_W-1:0]  x_base, y_base, px, py;

  logic                     vv1, v1_ready, o_ready;
  logic [VNUM_W-1:0]        a_num;
  logic signed [ACC_W-1:0]  a_px, a_py;
  logic [UV_W-1:0]          a_u, a_v;
  logic [COLOR_W-1:0]       a_color;
  logic                     a_last;

  sqvg_setup u_setup (
    .clk            (clk),
    .rst            (rst),
    .sprite_valid   (sprite_valid),
    .sprite_stall   (sprite_stall),
    .sprite_width   (sprite_width),
    .sprite_height  (sprite_height),
    .uv_min         (uv_min),
    .uv_max         (uv_max),
    .base_x         (base_x),
    .base_y         (base_y),
    .color_rgba     (color_rgba),
    .scale_factor   (scale_factor),
    .rotation_angle (rotation_angle),
    .crop_start     (crop_start),
    .crop_end       (crop_end),
    .result_valid   (s_valid),
    .result_stall   (s_stall),
    .result         (s_res)
  );

  assign o_ready  = !vertex_valid || !vertex_stall;
  assign v1_ready = !vv1 || o_ready;
  assign issue    = ev && v1_ready;
  assign e_done   = issue && (cnt == LAST_CORNER);
  assign e_ready  = !ev || e_done;
  assign s_stall  = !e_ready;

  assign right  = CORNER_RIGHT[cnt];
  assign top    = CORNER_TOP[cnt];
  assign x_base = (ACC_W'(e_cx2) <<< TRIG_FRACTION_BITS) + ACC_W'(ROUND_TRIG);
  assign y_base = (ACC_W'(e_cy2) <<< TRIG_FRACTION_BITS) + ACC_W'(ROUND_TRIG);
  assign px = x_base + (right ? ACC_W'(e_pa) : -ACC_W'(e_pa))
                     + (top ? -ACC_W'(e_pb) : ACC_W'(e_pb));
  assign py = y_base + (right ? ACC_W'(e_pc) : -ACC_W'(e_pc))
                     + (top ? ACC_W'(e_pd) : -ACC_W'(e_pd));

  always_ff @(posedge clk) begin
    if (rst) begin
      ev           <= 1'b0;
      cnt          <= FIRST_CORNER;
      vv1          <= 1'b0;
      vertex_valid <= 1'b0;
    end else begin
      if (e_ready) begin
        ev  <= s_valid;
        cnt <= FIRST_CORNER;
      end else if (issue) begin
        cnt <= cnt + VNUM_W'(1);
      end
      if (v1_ready) begin
        vv1 <= ev;
      end
      if (o_ready) begin
        vertex_valid <= vv1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready) begin
      e_cx2   <= s_res.cx2;
      e_cy2   <= s_res.cy2;
      e_pa    <= PROD_W'(s_res.cw) * PROD_W'(s_res.cn);
      e_pb    <= PROD_W'($signed({1'b0, s_res.sh})) * PROD_W'(s_res.sn);
      e_pc    <= PROD_W'(s_res.cw) * PROD_W'(s_res.sn);
      e_pd    <= PROD_W'($signed({1'b0, s_res.sh})) * PROD_W'(s_res.cn);
      e_ul    <= s_res.ul;
      e_ur    <= s_res.ur;
      e_vmin  <= s_res.vmin;
      e_vmax  <= s_res.vmax;
      e_color <= s_res.color;
    end
    if (v1_ready) begin
      a_num   <= cnt;
      a_px    <= px;
      a_py    <= py;
      a_u     <= right ? e_ur : e_ul;
      a_v     <= top ? e_vmax : e_vmin;
      a_color <= e_color;
      a_last  <= (cnt == LAST_CORNER);
    end
    if (o_ready) begin
      vertex_number <= a_num;
      vertex_x      <= sat_pos(RND_W'(a_px >>> (TRIG_FRACTION_BITS + 1)));
      vertex_y      <= sat_pos(RND_W'(a_py >>> (TRIG_FRACTION_BITS + 1)));
      tex_u         <= a_u;
      tex_v         <= a_v;
      vertex_color  <= a_color;
      last_vertex   <= a_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_is_tr: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && last_vertex |-> vertex_number == LAST_CORNER)
    else $error("last vertex flag on a corner other than TR");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    ev |-> cnt <= LAST_CORNER)
    else $error("corner counter out of range");

  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    ev && !v1_ready |=> ev && $stable(cnt))
    else $error("corner counter moved while the sum stage was full");

  a_cnt_wrap: assert property (@(posedge clk) disable iff (rst)
    e_done |=> cnt == FIRST_CORNER)
    else $error("corner counter did not restart after the last corner");
`endif

endmodule
